/* rtl/core/srtf_preemptive_scheduler_defines.svh */
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler_defines.svh
// assertion macros shared by the scheduler rtl
// ----------------------------------------------------------------------------
`ifndef SRTF_PREEMPTIVE_SCHEDULER_DEFINES_SVH
`define SRTF_PREEMPTIVE_SCHEDULER_DEFINES_SVH

// property must hold at every rising clock edge outside reset
`define SRTF_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// expression must never be true outside reset
`define SRTF_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

/* rtl/core/srtf_pkg.sv */
// ----------------------------------------------------------------------------
// srtf_pkg
// shared types and constants of the srtf scheduler
// ----------------------------------------------------------------------------
package srtf_pkg;

	localparam int TIME_W       = 16;
	localparam int BURST_W      = 12;
	localparam int ID_W         = 5;
	localparam int MAX_JOBS_DEF = 16;

	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TICK  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [TIME_W-1:0]  arrival_time;
		logic [BURST_W-1:0] burst_time;
	} cmd_t;

	typedef struct packed {
		logic [TIME_W-1:0] tick_time;
		logic [ID_W-1:0]   running_id;
		logic              finished;
		logic [TIME_W-1:0] completion_time;
		logic [TIME_W-1:0] turnaround;
		logic [TIME_W-1:0] waiting;
		logic              all_done;
	} res_t;

	// controls from the sequencer to the job table
	typedef struct packed {
		logic load;
		logic update;
		logic fin;
		logic clear;
	} tbl_ctl_t;

endpackage

/* rtl/core/srtf_job_table.sv */
// ----------------------------------------------------------------------------
// srtf_job_table
// job storage: arrival, burst and remaining memories plus done marks
// ----------------------------------------------------------------------------
module srtf_job_table #(
	parameter int MAX_JOBS = srtf_pkg::MAX_JOBS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  srtf_pkg::tbl_ctl_t           ctl,
	input  logic [$clog2(MAX_JOBS)-1:0]  wr_addr,
	input  logic [srtf_pkg::TIME_W-1:0]  wr_arr,
	input  logic [srtf_pkg::BURST_W-1:0] wr_bur,
	input  logic [srtf_pkg::BURST_W-1:0] wr_rem,
	input  logic [$clog2(MAX_JOBS)-1:0]  rd_addr,
	output logic [srtf_pkg::TIME_W-1:0]  rd_arr,
	output logic [srtf_pkg::BURST_W-1:0] rd_bur,
	output logic [srtf_pkg::BURST_W-1:0] rd_rem,
	output logic                         rd_done
);

	logic [srtf_pkg::TIME_W-1:0]  arr_mem [MAX_JOBS];
	logic [srtf_pkg::BURST_W-1:0] bur_mem [MAX_JOBS];
	logic [srtf_pkg::BURST_W-1:0] rem_mem [MAX_JOBS];
	logic [MAX_JOBS-1:0]          done_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			arr_mem[wr_addr] <= wr_arr;
			bur_mem[wr_addr] <= wr_bur;
		end
		if (ctl.load || ctl.update) begin
			rem_mem[wr_addr] <= wr_rem;
		end
		rd_arr  <= arr_mem[rd_addr];
		rd_bur  <= bur_mem[rd_addr];
		rd_rem  <= rem_mem[rd_addr];
		rd_done <= done_q[rd_addr];
	end

	// done marks reset as a whole, so they live in flops
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (ctl.clear) begin
			done_q <= '0;
		end else begin
			if (ctl.load) begin
				done_q[wr_addr] <= 1'b0;
			end
			if (ctl.update && ctl.fin) begin
				done_q[wr_addr] <= 1'b1;
			end
		end
	end

endmodule

/* rtl/core/srtf_preemptive_scheduler.sv */
// ----------------------------------------------------------------------------
// srtf_preemptive_scheduler
// preemptive shortest-remaining-time-first job scheduler
// ----------------------------------------------------------------------------
// usage
//   cmd channel (cmd_valid/cmd_ready, payload cmd) carries load, tick and clear
//   transactions; res channel (res_valid/res_ready, payload res) carries one
//   result transaction per tick, none for load, clear or the unused op code
//   load and clear are handled in the idle state, which the block does not leave
//   a tick is worked through in order: the table has one read port with a
//   registered read, so the search reads one entry a cycle and then drains the
//   last read; then come the update, turnaround and waiting on the shared
//   subtractor, and the output register; a new tick is taken only after the
//   result of the last one has gone into the output register
//   cmd_ready is high only while the sequencer is idle; the block keeps
//   taking commands while a result waits in the output register, and a
//   following tick holds in its last state until that register is free
//   reset empties the table, zeroes time and both job counters and drops any
//   pending result; the memories themselves are not cleared, only entries
//   below the fill count are ever read
// ----------------------------------------------------------------------------
`include "srtf_preemptive_scheduler_defines.svh"

module srtf_preemptive_scheduler #(
	parameter int MAX_JOBS = srtf_pkg::MAX_JOBS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  srtf_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output srtf_pkg::res_t res
);

	localparam int IDX_W = $clog2(MAX_JOBS);
	localparam int CNT_W = $clog2(MAX_JOBS + 1);
	localparam int TW    = srtf_pkg::TIME_W;
	localparam int BW    = srtf_pkg::BURST_W;
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_JOBS);
	localparam logic [TW-1:0]    TIME_MAX = '1;

	// one-hot sequencer
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_SCAN   = 6'b000010,
		ST_UPDATE = 6'b000100,
		ST_TAT    = 6'b001000,
		ST_WAIT   = 6'b010000,
		ST_RESULT = 6'b100000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   loaded_q;
	logic [CNT_W-1:0]   fin_cnt_q;
	logic [TW-1:0]      time_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               pend_s1;
	logic [IDX_W-1:0]   idx_s1;

	// best candidate so far
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [BW-1:0]      best_rem_q;
	logic [TW-1:0]      best_arr_q;
	logic [BW-1:0]      best_bur_q;

	logic               fin_q;
	logic [TW-1:0]      comp_q;
	logic [TW-1:0]      tat_q;
	logic [TW-1:0]      wait_q;

	srtf_pkg::res_t     res_q;
	logic               res_valid_q;

	// table side
	srtf_pkg::tbl_ctl_t tbl_ctl;
	logic [IDX_W-1:0]   tbl_wr_addr;
	logic [BW-1:0]      tbl_wr_rem;
	logic [TW-1:0]      rd_arr;
	logic [BW-1:0]      rd_bur;
	logic [BW-1:0]      rd_rem;
	logic               rd_done;

	logic               cmd_fire;
	logic               load_ok;
	logic               issue;
	logic               cand;
	logic               better;
	logic [BW-1:0]      rem_dec;
	logic               res_free;

	// shared subtractor, borrow in the top bit
	logic [TW-1:0]      sub_a;
	logic [TW-1:0]      sub_b;
	logic [TW:0]        sub_d;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cmd_fire  = cmd_valid && cmd_ready;
	assign load_ok   = cmd_fire && (cmd.op == srtf_pkg::OP_LOAD) && (loaded_q < CNT_MAX)
		&& (cmd.burst_time != '0);

	// one table read per scan cycle while entries remain
	assign issue = (state_q == ST_SCAN) && (rd_idx_q < loaded_q);

	// candidate must have arrived and be unfinished; ties fall to earlier arrival,
	// then to the lower id because the scan runs upwards with a strict compare
	assign cand   = pend_s1 && !rd_done && (rd_arr <= time_q);
	assign better = !found_q || (rd_rem < best_rem_q)
		|| ((rd_rem == best_rem_q) && (rd_arr < best_arr_q));

	assign rem_dec = (best_rem_q != '0) ? best_rem_q - BW'(1) : '0;

	always_comb begin
		tbl_ctl.load   = load_ok;
		tbl_ctl.update = (state_q == ST_UPDATE) && found_q;
		tbl_ctl.fin    = (rem_dec == '0);
		tbl_ctl.clear  = cmd_fire && (cmd.op == srtf_pkg::OP_CLEAR);
	end

	assign tbl_wr_addr = load_ok ? loaded_q[IDX_W-1:0] : best_idx_q;
	assign tbl_wr_rem  = load_ok ? cmd.burst_time : rem_dec;

	srtf_job_table #(
		.MAX_JOBS (MAX_JOBS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (tbl_ctl),
		.wr_addr (tbl_wr_addr),
		.wr_arr  (cmd.arrival_time),
		.wr_bur  (cmd.burst_time),
		.wr_rem  (tbl_wr_rem),
		.rd_addr (rd_idx_q[IDX_W-1:0]),
		.rd_arr  (rd_arr),
		.rd_bur  (rd_bur),
		.rd_rem  (rd_rem),
		.rd_done (rd_done)
	);

	// turnaround first, then waiting from it
	always_comb begin
		if (state_q == ST_TAT) begin
			sub_a = comp_q;
			sub_b = best_arr_q;
		end else begin
			sub_a = tat_q;
			sub_b = TW'(best_bur_q);
		end
		sub_d = {1'b0, sub_a} - {1'b0, sub_b};
	end

	assign res_free = !res_valid_q || res_ready;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			loaded_q    <= '0;
			fin_cnt_q   <= '0;
			time_q      <= '0;
			rd_idx_q    <= '0;
			pend_s1     <= 1'b0;
			found_q     <= 1'b0;
			fin_q       <= 1'b0;
		end else begin
			pend_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_fire) begin
						case (cmd.op)
							srtf_pkg::OP_LOAD: begin
								if (load_ok) begin
									loaded_q <= loaded_q + CNT_W'(1);
								end
							end
							srtf_pkg::OP_TICK: begin
								rd_idx_q <= '0;
								found_q  <= 1'b0;
								state_q  <= ST_SCAN;
							end
							srtf_pkg::OP_CLEAR: begin
								loaded_q  <= '0;
								fin_cnt_q <= '0;
								time_q    <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (cand && better) begin
						found_q <= 1'b1;
					end
					if (!issue && !pend_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					fin_q <= found_q && (rem_dec == '0);
					if (found_q && (rem_dec == '0)) begin
						fin_cnt_q <= fin_cnt_q + CNT_W'(1);
					end
					state_q <= ST_TAT;
				end
				ST_TAT: begin
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					state_q <= ST_RESULT;
				end
				ST_RESULT: begin
					if (res_free) begin
						if (time_q != TIME_MAX) begin
							time_q <= time_q + TW'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register valid flag: set by a finished tick, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == ST_RESULT) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (cand && better) begin
			best_idx_q <= idx_s1;
			best_rem_q <= rd_rem;
			best_arr_q <= rd_arr;
			best_bur_q <= rd_bur;
		end
		if (state_q == ST_UPDATE) begin
			comp_q <= (time_q != TIME_MAX) ? time_q + TW'(1) : TIME_MAX;
		end
		if (state_q == ST_TAT) begin
			tat_q <= sub_d[TW-1:0];
		end
		if (state_q == ST_WAIT) begin
			// waiting floors at zero, only reachable once time has saturated
			wait_q <= sub_d[TW] ? '0 : sub_d[TW-1:0];
		end
		if ((state_q == ST_RESULT) && res_free) begin
			res_q.tick_time       <= time_q;
			res_q.running_id      <= found_q
				? srtf_pkg::ID_W'(32'(best_idx_q) + 32'd1) : '0;
			res_q.finished        <= fin_q;
			res_q.completion_time <= fin_q ? comp_q : '0;
			res_q.turnaround      <= fin_q ? tat_q : '0;
			res_q.waiting         <= fin_q ? wait_q : '0;
			res_q.all_done        <= (fin_cnt_q == loaded_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// checks
	`SRTF_ASSERT_NEVER(a_fin_le_loaded, fin_cnt_q > loaded_q, "more jobs finished than loaded")
	`SRTF_ASSERT(a_res_from_tick, $rose(res_valid_q) |-> $past(state_q == ST_RESULT), "result without tick")
	`SRTF_ASSERT(a_time_mono, !(cmd_fire && (cmd.op == srtf_pkg::OP_CLEAR)) |=> time_q >= $past(time_q), "time went back")

endmodule
